FILE: rtl/core/swrpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swrpm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLTS_PER_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQRT_TERM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR_TERM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFFSET_TERM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_FLOOR    = 3'd4;

	localparam logic [23:0] VPC_RESET   = 24'd13519;
	localparam logic [19:0] COEF_A_RST  = 20'sd74567;
	localparam logic [19:0] COEF_B_RST  = 20'sd82169;
	localparam logic [19:0] COEF_C_RST  = -20'sd5607;
	localparam logic [15:0] FLOOR_RESET = 16'd655;

	localparam logic [23:0] POWER_MAX = 24'hFFFFFF;
	localparam logic [14:0] SWR_ONE   = 15'd256;
	localparam logic [14:0] SWR_MAX   = 15'd25574;

	// Accumulator for a*sqrt(V) + b*V, and the rounded power before saturation.
	localparam int ACC_W = 56;
	localparam int P_W   = ACC_W - 14;

	typedef struct packed {
		logic       op;
		logic [9:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [23:0] power;
		logic [14:0] swr;
		logic        swr_valid;
	} out_item_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_DIV_V,
		DP_SQRT_V,
		DP_MAC,
		DP_ROUND,
		DP_REV_CHK,
		DP_DIV_R,
		DP_SQRT_R,
		DP_DIV_S,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic op_rev;
		logic rev_zero;
		logic rev_sat;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/swrpm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module swrpm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [23:0] divisor,
	output logic             busy,
	output logic [63:0]      quot
);
	logic [23:0] rem_q;
	logic [23:0] dvs_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic [24:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[63]};
	assign fits   = rem_sh >= {1'b0, dvs_q};
	assign busy   = cnt_q != 7'd0;
	assign quot   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 24'd0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= fits ? 24'(rem_sh - {1'b0, dvs_q}) : rem_sh[23:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/swrpm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Integer square root, two radicand bits per cycle.
module swrpm_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic [31:0]      root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        fits;

	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;
	assign busy   = cnt_q != 6'd0;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= 34'd0;
			root_q <= 32'd0;
		end else if (busy) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/swrpm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module swrpm_dp #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire swrpm_pkg::dp_cmd_t                  cmd,
	output swrpm_pkg::dp_stat_t                      stat,
	input  wire swrpm_pkg::in_item_t                 in_item,
	output swrpm_pkg::out_item_t                     out_item,
	input  wire logic                                cfg_we,
	input  wire logic [swrpm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [swrpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int ACC_W = swrpm_pkg::ACC_W;
	localparam int P_W   = swrpm_pkg::P_W;
	localparam logic [15:0] SMAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [37:0] RECIP5 = 38'd219902325556;

	logic [23:0]             vpc_q;
	logic signed [19:0]      coef_a_q, coef_b_q, coef_c_q;
	logic [15:0]             floor_q;
	logic [23:0]             fwd_q;
	logic [23:0]             pw_q;
	logic                    op_q;
	logic [45:0]             y_q;
	logic [33:0]             v_q;
	logic signed [36:0]      prod_q;
	logic [5:0]              sh_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [P_W-1:0]   p_q;
	swrpm_pkg::out_item_t    res_q;

	// Sample clamp and the volts product.
	logic [15:0] s_raw, s_cl;
	logic [20:0] k14;
	logic [45:0] y_nx;
	always_comb begin
		s_raw = {6'd0, in_item.sample} & SMAX;
		s_cl  = (s_raw == 16'd0) ? 16'd1 : s_raw;
		k14   = 21'({s_cl, 1'b1}) * 21'd14;
		y_nx  = 46'(k14) * 46'(vpc_q) + 46'd1280;
	end

	// Volts scaling. y/2560 equals floor(y/512)/5, and the divide by five is a
	// multiply by ceil(2^40/5), exact for dividends below 2^38. The product is
	// built from one 16-bit slice of the dividend per cycle, top slice first.
	logic [47:0] vx_q;
	logic [73:0] vacc_q;
	logic [1:0]  vcnt_q;
	logic        v_busy;
	logic [53:0] v_part;
	logic [33:0] v_nx;
	assign v_busy = vcnt_q != 2'd0;
	assign v_part = 54'(vx_q[47:32]) * 54'(RECIP5);
	assign v_nx   = vacc_q[73:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= 2'd0;
		end else if (cmd.op == swrpm_pkg::DP_DIV_V) begin
			vcnt_q <= 2'd3;
		end else if (v_busy) begin
			vcnt_q <= vcnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == swrpm_pkg::DP_DIV_V) begin
			vx_q   <= {11'd0, y_q[45:9]};
			vacc_q <= '0;
		end else if (v_busy) begin
			vx_q   <= vx_q << 16;
			vacc_q <= (vacc_q << 16) + 74'(v_part);
		end
	end

	// Shared units.
	logic        div_start, sqrt_start;
	logic [63:0] div_dividend, sqrt_rad, quot;
	logic [23:0] div_divisor;
	logic [31:0] root;
	logic        div_busy, sqrt_busy;
	logic [16:0] g, den;
	logic [26:0] swr_num;

	always_comb begin
		g       = root[16:0];
		den     = 17'd65536 - g;
		swr_num = 27'((17'd65536 + g)) * 27'd512 + 27'(den);
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		div_dividend = {8'd0, pw_q, 32'd0};
		div_divisor  = fwd_q;
		sqrt_rad     = {14'd0, v_nx, 16'd0};
		case (cmd.op)
			swrpm_pkg::DP_SQRT_V: sqrt_start = 1'b1;
			swrpm_pkg::DP_DIV_R: div_start = 1'b1;
			swrpm_pkg::DP_SQRT_R: begin
				sqrt_start = 1'b1;
				sqrt_rad   = {32'd0, quot[31:0]};
			end
			swrpm_pkg::DP_DIV_S: begin
				div_start    = 1'b1;
				div_dividend = 64'(swr_num);
				div_divisor  = 24'({den, 1'b0});
			end
			default: ;
		endcase
	end

	swrpm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .busy(div_busy), .quot(quot)
	);

	swrpm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(sqrt_rad),
		.busy(sqrt_busy), .root(root)
	);

	// Partial product selection: a*sqrt(V) in two slices, b*V in three.
	logic signed [19:0] mul_coef;
	logic [15:0]        mul_chunk;
	logic [5:0]         mul_sh;
	logic signed [36:0] mul_p;
	always_comb begin
		mul_coef  = coef_a_q;
		mul_chunk = 16'd0;
		mul_sh    = 6'd0;
		case (cmd.idx)
			3'd0: mul_chunk = root[15:0];
			3'd1: begin mul_chunk = root[31:16]; mul_sh = 6'd16; end
			3'd2: begin mul_coef = coef_b_q; mul_chunk = v_q[15:0]; end
			3'd3: begin mul_coef = coef_b_q; mul_chunk = v_q[31:16]; mul_sh = 6'd16; end
			3'd4: begin mul_coef = coef_b_q; mul_chunk = {14'd0, v_q[33:32]}; mul_sh = 6'd32; end
			default: ;
		endcase
		mul_p = mul_coef * $signed({1'b0, mul_chunk});
	end

	logic signed [ACC_W-1:0] prod_ext;
	assign prod_ext = $signed({{(ACC_W-37){prod_q[36]}}, prod_q}) <<< sh_q;

	// Round half away from zero, then add the offset.
	logic [ACC_W-1:0]      acc_mag;
	logic [ACC_W-17:0]     rnd;
	logic signed [P_W-1:0] lin, p_nx;
	always_comb begin
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		rnd     = (ACC_W-16)'((acc_mag + ACC_W'(32768)) >> 16);
		lin     = acc_q[ACC_W-1] ? -$signed(P_W'(rnd)) : $signed(P_W'(rnd));
		p_nx    = lin + P_W'(coef_c_q);
	end

	logic [23:0] p_sat;
	logic        p_below;
	always_comb begin
		if (p_q < 0) p_sat = 24'd0;
		else if (p_q > $signed(P_W'(swrpm_pkg::POWER_MAX))) p_sat = swrpm_pkg::POWER_MAX;
		else p_sat = p_q[23:0];
		p_below = p_q < $signed(P_W'(floor_q));
	end

	logic [14:0] swr_q;
	always_comb begin
		if (quot > 64'(swrpm_pkg::SWR_MAX)) swr_q = swrpm_pkg::SWR_MAX;
		else if (quot < 64'(swrpm_pkg::SWR_ONE)) swr_q = swrpm_pkg::SWR_ONE;
		else swr_q = quot[14:0];
	end

	// The volts scaling reports through the divider busy flag.
	assign stat.div_busy  = div_busy || v_busy;
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.op_rev    = op_q;
	assign stat.rev_zero  = pw_q == 24'd0;
	assign stat.rev_sat   = (fwd_q == 24'd0) || (pw_q >= fwd_q);
	assign out_item       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpc_q    <= swrpm_pkg::VPC_RESET;
			coef_a_q <= swrpm_pkg::COEF_A_RST;
			coef_b_q <= swrpm_pkg::COEF_B_RST;
			coef_c_q <= swrpm_pkg::COEF_C_RST;
			floor_q  <= swrpm_pkg::FLOOR_RESET;
			fwd_q    <= 24'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					swrpm_pkg::CFG_VOLTS_PER_COUNT:  vpc_q    <= cfg_data;
					swrpm_pkg::CFG_COEF_SQRT_TERM:   coef_a_q <= cfg_data[19:0];
					swrpm_pkg::CFG_COEF_LINEAR_TERM: coef_b_q <= cfg_data[19:0];
					swrpm_pkg::CFG_COEF_OFFSET_TERM: coef_c_q <= cfg_data[19:0];
					swrpm_pkg::CFG_REVERSE_FLOOR:    floor_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == swrpm_pkg::DP_FINISH && !op_q) begin
				fwd_q <= p_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			swrpm_pkg::DP_LOAD: begin
				op_q <= in_item.op;
				y_q  <= y_nx;
			end
			swrpm_pkg::DP_SQRT_V: v_q <= v_nx;
			swrpm_pkg::DP_MAC: begin
				prod_q <= mul_p;
				sh_q   <= mul_sh;
				acc_q  <= (cmd.idx == 3'd0) ? '0 : acc_q + prod_ext;
			end
			swrpm_pkg::DP_ROUND: p_q <= p_nx;
			swrpm_pkg::DP_REV_CHK: pw_q <= p_below ? 24'd0 : p_sat;
			swrpm_pkg::DP_FINISH: begin
				if (!op_q) begin
					res_q.power     <= p_sat;
					res_q.swr       <= swrpm_pkg::SWR_ONE;
					res_q.swr_valid <= 1'b0;
				end else begin
					res_q.power     <= pw_q;
					res_q.swr_valid <= 1'b1;
					if (pw_q == 24'd0) res_q.swr <= swrpm_pkg::SWR_ONE;
					else if (stat.rev_sat) res_q.swr <= swrpm_pkg::SWR_MAX;
					else res_q.swr <= swr_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/swrpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module swrpm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output swrpm_pkg::dp_cmd_t       cmd,
	input  wire swrpm_pkg::dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIV_V, S_WAIT_V, S_SQRT_V, S_WSQ_V, S_MAC, S_ROUND, S_REV_CHK,
		S_REV_DEC, S_DIV_R, S_WAIT_R, S_SQRT_R, S_WSQ_R, S_DIV_S, S_WAIT_S, S_FIN
	} state_t;

	state_t     state_q;
	logic [2:0] mac_q;
	logic       out_valid_q;
	logic       fin_go;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign fin_go    = !out_valid_q || out_ready;

	always_comb begin
		cmd.op  = swrpm_pkg::DP_NOP;
		cmd.idx = mac_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) cmd.op = swrpm_pkg::DP_LOAD;
			S_DIV_V:   cmd.op = swrpm_pkg::DP_DIV_V;
			S_SQRT_V:  cmd.op = swrpm_pkg::DP_SQRT_V;
			S_MAC:     cmd.op = swrpm_pkg::DP_MAC;
			S_ROUND:   cmd.op = swrpm_pkg::DP_ROUND;
			S_REV_CHK: cmd.op = swrpm_pkg::DP_REV_CHK;
			S_DIV_R:   cmd.op = swrpm_pkg::DP_DIV_R;
			S_SQRT_R:  cmd.op = swrpm_pkg::DP_SQRT_R;
			S_DIV_S:   cmd.op = swrpm_pkg::DP_DIV_S;
			S_FIN:     if (fin_go) cmd.op = swrpm_pkg::DP_FINISH;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mac_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DIV_V;
				S_DIV_V:  state_q <= S_WAIT_V;
				S_WAIT_V: if (!stat.div_busy) state_q <= S_SQRT_V;
				S_SQRT_V: state_q <= S_WSQ_V;
				S_WSQ_V: begin
					if (!stat.sqrt_busy) begin
						state_q <= S_MAC;
						mac_q   <= 3'd0;
					end
				end
				S_MAC: begin
					mac_q <= mac_q + 3'd1;
					if (mac_q == 3'd5) state_q <= S_ROUND;
				end
				S_ROUND:   state_q <= stat.op_rev ? S_REV_CHK : S_FIN;
				S_REV_CHK: state_q <= S_REV_DEC;
				S_REV_DEC: state_q <= (stat.rev_zero || stat.rev_sat) ? S_FIN : S_DIV_R;
				S_DIV_R:   state_q <= S_WAIT_R;
				S_WAIT_R:  if (!stat.div_busy) state_q <= S_SQRT_R;
				S_SQRT_R:  state_q <= S_WSQ_R;
				S_WSQ_R:   if (!stat.sqrt_busy) state_q <= S_DIV_S;
				S_DIV_S:   state_q <= S_WAIT_S;
				S_WAIT_S:  if (!stat.div_busy) state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/swr_power_meter_calc_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Forward/reflected power and SWR meter.
// The input channel (in_valid/in_ready/in_item) takes one item per detector
// reading: op selects a forward sample (stored as the forward power) or a
// reverse sample (which also yields an SWR figure). Each item gives exactly one
// result item on the output channel (out_valid/out_ready/out_item).
// One item is worked on at a time. A forward item runs a sliced reciprocal
// multiply for the volts scaling, a square root and the multiply-accumulate
// steps. A reverse item with zero power or a ratio at or above one skips the
// SWR path. A reverse item that needs the full SWR path runs the 64-step
// divider twice and the root unit once more. The next item can be accepted
// once the result is registered, as the controller returns to idle when it
// registers the result. Configuration registers are written through
// cfg_we/cfg_idx/cfg_data; the user must write them only while no item is in
// flight, as the block itself does not enforce this. Reset clears the stored
// forward power and loads the default calibration. A finished result sits in
// an output register; while the receiver stalls, the next item is still
// accepted and computed, and it waits for the output register to empty
// before being published.
module swr_power_meter_calc_top #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire swrpm_pkg::in_item_t              in_item,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output swrpm_pkg::out_item_t                  out_item,
	input  wire logic                             cfg_we,
	input  wire logic [swrpm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [swrpm_pkg::CFG_DATA_W-1:0] cfg_data
);
	swrpm_pkg::dp_cmd_t  cmd;
	swrpm_pkg::dp_stat_t stat;

	// The controller sequences the steps; the datapath owns all arithmetic.
	swrpm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
	);

	swrpm_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_item(in_item),
		.out_item(out_item), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);
endmodule
`default_nettype wire

FILE: rtl/core/swrpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module swrpm_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire swrpm_pkg::out_item_t out_item
);
	// One item in flight: acceptance closes the input for the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_fwd_swr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.swr_valid |-> out_item.swr == swrpm_pkg::SWR_ONE)
		else $error("forward item swr not one");

	a_swr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.swr >= swrpm_pkg::SWR_ONE && out_item.swr <= swrpm_pkg::SWR_MAX)
		else $error("swr out of range");
endmodule

bind swr_power_meter_calc_top swrpm_checker u_swrpm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
`default_nettype wire
